// ===== hdl/u2a_pkg.sv =====
`timescale 1ns / 1ps

package u2a_pkg;

	// Full-width ASCII block and its offset to the basic Latin range
	localparam logic [20:0] CpLow    = 21'h00FF01;
	localparam logic [20:0] CpHigh   = 21'h00FF5E;
	localparam logic [20:0] CpOffset = 21'h00FEE0;

	localparam logic [7:0] ContMask = 8'h3F;
	localparam logic [7:0] Lead2Mask = 8'h1F;
	localparam logic [7:0] Lead3Mask = 8'h0F;
	localparam logic [7:0] Lead4Mask = 8'h07;

	localparam int MaxOut = 4;

	// Bytes produced by one input byte, handed from decoder to emitter
	typedef struct packed {
		logic [MaxOut-1:0][7:0] bytes;
		logic [2:0]             count;
		logic                   fin;
	} dec_res_t;

endpackage

// ===== hdl/utf8_fullwidth_to_ascii.sv =====
`timescale 1ns / 1ps
// Path: the first result byte of an input transaction passes the input stage and then the
// emitter's output register before it is valid on m_tdata.
// Throughput: one input byte per cycle while each byte yields at most one result byte and m_tready is high;
// a byte that flushes n held bytes occupies the single output register until all n + 1 bytes are taken.
// Reset: arst_n clears the input stage, the decoder state and the output stage at once;
// the converter then waits idle for the first byte of a string.
module utf8_fullwidth_to_ascii (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] in_byte
	input  logic       s_tlast,   // is_final
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic       m_tlast,   // run_end
	output logic       m_tuser    // string_end
);

	// Input stage: one accepted byte waits here until the decoder can hand
	// its results to the emitter.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       final_s1;

	u2a_pkg::dec_res_t res;
	logic emit_ready;
	logic commit;

	// A byte that produces no output commits regardless of the emitter, so
	// the body of a multi-byte sequence never waits on the output side.
	assign commit   = valid_s1 && (res.count == 3'd0 || emit_ready);
	assign s_tready = !valid_s1 || commit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1  <= s_tdata;
			final_s1 <= s_tlast;
		end
	end

	// Decoder: sequence state and the list of bytes this input gives.
	u2a_decode u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.commit   (commit),
		.in_byte  (byte_s1),
		.in_final (final_s1),
		.res      (res)
	);

	// Emitter: holds one result list and plays it out a byte per cycle while m_tready is high.
	u2a_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (valid_s1 && res.count != 3'd0),
		.res      (res),
		.ready    (emit_ready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

`ifndef SYNTHESIS
	// The end of a string is always the end of a run.
	a_string_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> m_tlast)
		else $error("string end flagged on a byte that is not last of its run");

	// A byte held in the input stage stays until the decoder commits it.
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !commit) |=> (valid_s1 && $stable(byte_s1) && $stable(final_s1)))
		else $error("input stage lost a byte before commit");

	// A byte with results never commits while the emitter still plays out.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && res.count != 3'd0) |-> emit_ready)
		else $error("result list committed while emitter busy");
`endif

endmodule

// ===== hdl/u2a_decode.sv =====
`timescale 1ns / 1ps

module u2a_decode (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              commit,
	input  logic [7:0]        in_byte,
	input  logic              in_final,
	output u2a_pkg::dec_res_t res
);

	logic [20:0] acc_q;
	logic [1:0]  need_q;
	logic [1:0]  held_q;
	logic [2:0][7:0] raw_q;

	logic [20:0] acc_d;
	logic [1:0]  need_d;
	logic [1:0]  held_d;
	logic        store_lead;
	logic        store_cont;
	logic [20:0] acc_next;
	logic [20:0] acc_conv;
	logic [1:0]  lead_need;
	logic [20:0] lead_acc;
	logic        flush;

	always_comb begin
		if (in_byte[7:5] == 3'b110) begin
			lead_need = 2'd1;
			lead_acc  = {13'd0, in_byte & u2a_pkg::Lead2Mask};
		end else if (in_byte[7:4] == 4'b1110) begin
			lead_need = 2'd2;
			lead_acc  = {13'd0, in_byte & u2a_pkg::Lead3Mask};
		end else if (in_byte[7:3] == 5'b11110) begin
			lead_need = 2'd3;
			lead_acc  = {13'd0, in_byte & u2a_pkg::Lead4Mask};
		end else begin
			lead_need = 2'd0;
			lead_acc  = 21'd0;
		end
	end

	assign acc_next = {acc_q[14:0], in_byte[5:0] & u2a_pkg::ContMask[5:0]};
	assign acc_conv = acc_next - u2a_pkg::CpOffset;

	always_comb begin
		acc_d      = acc_q;
		need_d     = need_q;
		held_d     = held_q;
		store_lead = 1'b0;
		store_cont = 1'b0;
		flush      = 1'b0;
		res.fin    = in_final;
		res.bytes  = '0;
		res.count  = 3'd0;
		if (need_q == 2'd0) begin
			if (lead_need == 2'd0 || in_final) begin
				res.bytes[0] = in_byte;
				res.count    = 3'd1;
			end else begin
				store_lead = 1'b1;
				acc_d      = lead_acc;
				need_d     = lead_need;
				held_d     = 2'd1;
			end
		end else if (need_q == 2'd1) begin
			if (acc_next >= u2a_pkg::CpLow && acc_next <= u2a_pkg::CpHigh) begin
				res.bytes[0] = acc_conv[7:0];
				res.count    = 3'd1;
			end else begin
				flush = 1'b1;
			end
			acc_d  = '0;
			need_d = 2'd0;
			held_d = 2'd0;
		end else if (in_final) begin
			flush  = 1'b1;
			acc_d  = '0;
			need_d = 2'd0;
			held_d = 2'd0;
		end else begin
			store_cont = 1'b1;
			acc_d      = acc_next;
			need_d     = need_q - 2'd1;
			held_d     = held_q + 2'd1;
		end
		if (flush) begin
			// Held bytes in order, then the current byte
			for (int i = 0; i < 3; i++) begin
				if (2'(i) < held_q) begin
					res.bytes[i] = raw_q[i];
				end
			end
			res.bytes[held_q] = in_byte;
			res.count         = {1'b0, held_q} + 3'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			need_q <= '0;
			held_q <= '0;
		end else if (commit) begin
			acc_q  <= acc_d;
			need_q <= need_d;
			held_q <= held_d;
		end
	end

	always_ff @(posedge clk) begin
		if (commit && store_lead) begin
			raw_q[0] <= in_byte;
		end
		if (commit && store_cont) begin
			raw_q[held_q] <= in_byte;
		end
	end

endmodule

// ===== hdl/u2a_emit.sv =====
`timescale 1ns / 1ps

module u2a_emit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  u2a_pkg::dec_res_t res,
	output logic              ready,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [7:0]        m_tdata,
	output logic              m_tlast,
	output logic              m_tuser
);

	logic [u2a_pkg::MaxOut-1:0][7:0] bytes_q;
	logic [2:0] count_q;
	logic [1:0] pos_q;
	logic       fin_q;
	logic       busy_q;
	logic       last;

	assign last     = ({1'b0, pos_q} + 3'd1) == count_q;
	assign ready    = !busy_q || (m_tready && last);
	assign m_tvalid = busy_q;
	assign m_tdata  = bytes_q[pos_q];
	assign m_tlast  = last;
	assign m_tuser  = last && fin_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			pos_q   <= '0;
			count_q <= '0;
		end else if (ready && load) begin
			busy_q  <= 1'b1;
			pos_q   <= '0;
			count_q <= res.count;
		end else if (busy_q && m_tready) begin
			if (last) begin
				busy_q <= 1'b0;
			end
			pos_q <= pos_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && load) begin
			bytes_q <= res.bytes;
			fin_q   <= res.fin;
		end
	end

endmodule
